[rtl/core/hlc_pkg.sv]
// ----------------------------------------------------------------------------
// hlc_pkg
// Shared types and constants of the homogeneous line clipper.
// ----------------------------------------------------------------------------
package hlc_pkg;

  localparam int DEF_COORD_WIDTH   = 32;
  localparam int DEF_FRACTION_BITS = 16;

  localparam int APB_ADDR_W = 4;
  localparam int APB_DATA_W = 32;

  localparam logic [1:0] REG_WIN_LEFT   = 2'd0;
  localparam logic [1:0] REG_WIN_RIGHT  = 2'd1;
  localparam logic [1:0] REG_WIN_TOP    = 2'd2;
  localparam logic [1:0] REG_WIN_BOTTOM = 2'd3;

  localparam logic [7:0] WIN_LEFT_RST   = 8'd0;
  localparam logic [7:0] WIN_RIGHT_RST  = 8'd127;
  localparam logic [7:0] WIN_TOP_RST    = 8'd0;
  localparam logic [7:0] WIN_BOTTOM_RST = 8'd63;

  typedef struct packed {
    logic [7:0] left;
    logic [7:0] right;
    logic [7:0] top;
    logic [7:0] bottom;
  } win_t;

  typedef enum logic {
    OP_DIV,
    OP_MUL
  } arith_op_t;

  typedef struct packed {
    logic      start;
    arith_op_t op;
  } arith_req_t;

endpackage

[rtl/core/hlc_arith.sv]
// ----------------------------------------------------------------------------
// hlc_arith
// Shared bit-serial unit: restoring divide or shift-add multiply, one bit
// per cycle.
// ----------------------------------------------------------------------------
module hlc_arith
  import hlc_pkg::*;
#(
  parameter int REM_W = DEF_COORD_WIDTH + 3,
  parameter int QUO_W = DEF_COORD_WIDTH + 10,
  parameter int CNT_W = $clog2(DEF_COORD_WIDTH + 11)
) (
  input  logic             clk,
  input  logic             rst_n,
  input  arith_req_t       req,
  input  logic [REM_W-1:0] a_init,
  input  logic [QUO_W-1:0] b_init,
  input  logic [REM_W-1:0] operand,
  input  logic [CNT_W-1:0] steps,
  output logic             done,
  output logic [REM_W-1:0] a_q,
  output logic [QUO_W-1:0] b_q
);

  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  arith_op_t        op_r, op_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [REM_W-1:0] a_r, a_nxt;
  logic [QUO_W-1:0] b_r, b_nxt;
  logic [REM_W-1:0] d_r, d_nxt;
  logic [REM_W-1:0] trial;
  logic [REM_W-1:0] acc;

  always_comb begin
    trial    = {a_r[REM_W-2:0], b_r[QUO_W-1]};
    acc      = a_r + (b_r[0] ? d_r : '0);
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    op_nxt   = op_r;
    cnt_nxt  = cnt_r;
    a_nxt    = a_r;
    b_nxt    = b_r;
    d_nxt    = d_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      op_nxt   = req.op;
      cnt_nxt  = steps;
      a_nxt    = a_init;
      b_nxt    = b_init;
      d_nxt    = operand;
    end else if (busy_r) begin
      unique case (op_r)
        OP_DIV: begin
          if (trial >= d_r) begin
            a_nxt = trial - d_r;
            b_nxt = {b_r[QUO_W-2:0], 1'b1};
          end else begin
            a_nxt = trial;
            b_nxt = {b_r[QUO_W-2:0], 1'b0};
          end
        end
        OP_MUL: begin
          a_nxt = {1'b0, acc[REM_W-1:1]};
          b_nxt = {acc[0], b_r[QUO_W-1:1]};
        end
        default: ;
      endcase
      cnt_nxt = cnt_r - CNT_W'(1);
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      op_r   <= OP_DIV;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      op_r   <= op_nxt;
      cnt_r  <= cnt_nxt;
    end
    a_r <= a_nxt;
    b_r <= b_nxt;
    d_r <= d_nxt;
  end

  assign done = done_r;
  assign a_q  = a_r;
  assign b_q  = b_r;

endmodule

[rtl/core/hlc_ctrl.sv]
// ----------------------------------------------------------------------------
// hlc_ctrl
// Sequencer: outcodes, plane parameters, interpolation, viewport mapping
// and result register. Divides and interpolation products use the shared unit.
// ----------------------------------------------------------------------------
module hlc_ctrl
  import hlc_pkg::*;
#(
  parameter int COORD_WIDTH   = DEF_COORD_WIDTH,
  parameter int FRACTION_BITS = DEF_FRACTION_BITS
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  win_t                          win,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_pen_down,
  input  logic signed [COORD_WIDTH-1:0] in_clip_x,
  input  logic signed [COORD_WIDTH-1:0] in_clip_y,
  input  logic signed [COORD_WIDTH-1:0] in_clip_z,
  input  logic signed [COORD_WIDTH-1:0] in_clip_w,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          out_is_line,
  output logic [7:0]                    out_start_x,
  output logic [7:0]                    out_start_y,
  output logic [7:0]                    out_end_x,
  output logic [7:0]                    out_end_y,
  output logic                          out_last_of_run
);

  localparam int CW   = COORD_WIDTH;
  localparam int FB   = FRACTION_BITS;
  localparam int DW   = CW + 1;
  localparam int MW   = CW + 2;
  localparam int RW   = CW + 3;
  localparam int PW   = CW + 10;
  localparam int QW   = PW;
  localparam int AW   = FB + 1;
  localparam int CNTW = $clog2(QW + 1);

  localparam logic [AW-1:0] ALPHA_ONE = {1'b1, {FB{1'b0}}};

  localparam logic [2:0] PL_XLO = 3'd0;
  localparam logic [2:0] PL_XHI = 3'd1;
  localparam logic [2:0] PL_YLO = 3'd2;
  localparam logic [2:0] PL_YHI = 3'd3;
  localparam logic [2:0] PL_ZLO = 3'd4;
  localparam logic [2:0] PL_ZHI = 3'd5;

  localparam logic [1:0] K_X = 2'd0;
  localparam logic [1:0] K_Y = 2'd1;
  localparam logic [1:0] K_W = 2'd3;

  typedef logic signed [CW-1:0] coord_t;

  typedef enum logic [4:0] {
    ST_IDLE, ST_DECIDE, ST_PDIST, ST_PMAG, ST_PCHK, ST_PDIV, ST_PUPD, ST_POST,
    ST_EXIT, ST_ISUB, ST_IMUL, ST_IWAIT, ST_MSUM, ST_MMUL, ST_MDIV0, ST_MDIV,
    ST_MSAT, ST_EMIT, ST_FINISH
  } state_t;

  state_t             state_r, state_nxt;
  coord_t             new_r [4];
  coord_t             new_nxt [4];
  coord_t             prev_r [4];
  coord_t             prev_nxt [4];
  coord_t             pt_r [4];
  coord_t             pt_nxt [4];
  logic [5:0]         nc_r, nc_nxt, oc_r, oc_nxt, prev_oc_r, prev_oc_nxt;
  logic               draw_r, draw_nxt;
  logic [2:0]         pl_r, pl_nxt;
  logic [1:0]         k_r, k_nxt;
  logic               ax_r, ax_nxt;
  logic [AW-1:0]      aold_r, aold_nxt, anew_r, anew_nxt, alpha_r, alpha_nxt;
  logic signed [DW-1:0] dold_r, dold_nxt, dnew_r, dnew_nxt, d_r, d_nxt, sum_r, sum_nxt;
  logic [MW-1:0]      num_r, num_nxt, den_r, den_nxt;
  logic signed [PW-1:0] prod_r, prod_nxt, scl_r, scl_nxt;
  logic               neg_r, neg_nxt;
  logic               line_r, line_nxt, last_r, last_nxt;
  logic [7:0]         ex_r, ex_nxt, ey_r, ey_nxt;
  logic [7:0]         pen_x_r, pen_x_nxt, pen_y_r, pen_y_nxt;
  logic               ov_r, ov_nxt, oline_r, oline_nxt, olast_r, olast_nxt;
  logic [7:0]         osx_r, osx_nxt, osy_r, osy_nxt, oex_r, oex_nxt, oey_r, oey_nxt;

  logic signed [DW-1:0] ix, iy, iz, iw, sxl, sxh, syl, syh, szl;
  logic [5:0]         nc_in;
  logic [5:0]         mask;
  logic signed [MW-1:0] diff, dold_ext;
  logic signed [8:0]  span;
  logic signed [PW:0] cv;
  logic [AW-1:0]      upd_old, upd_new;
  logic [DW-1:0]      pmul;
  logic signed [DW-1:0] pa;
  coord_t             pw;

  arith_req_t         ar_req;
  logic [RW-1:0]      ar_a_init, ar_operand, ar_a;
  logic [QW-1:0]      ar_b_init, ar_b;
  logic [CNTW-1:0]    ar_steps;
  logic               ar_done;

  hlc_arith #(
    .REM_W (RW),
    .QUO_W (QW),
    .CNT_W (CNTW)
  ) u_arith (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (ar_req),
    .a_init  (ar_a_init),
    .b_init  (ar_b_init),
    .operand (ar_operand),
    .steps   (ar_steps),
    .done    (ar_done),
    .a_q     (ar_a),
    .b_q     (ar_b)
  );

  function automatic logic signed [DW-1:0] pdist(input coord_t vx, input coord_t vy,
                                                  input coord_t vz, input coord_t vw,
                                                  input logic [2:0] pl);
    logic signed [DW-1:0] r;
    unique case (pl)
      PL_XLO:  r = DW'(vx) + DW'(vw);
      PL_XHI:  r = DW'(vx) - DW'(vw);
      PL_YLO:  r = DW'(vy) + DW'(vw);
      PL_YHI:  r = DW'(vy) - DW'(vw);
      PL_ZLO:  r = DW'(vz) + DW'(vw);
      PL_ZHI:  r = DW'(vz);
      default: r = '0;
    endcase
    return r;
  endfunction

  assign ix  = DW'(in_clip_x);
  assign iy  = DW'(in_clip_y);
  assign iz  = DW'(in_clip_z);
  assign iw  = DW'(in_clip_w);
  assign sxl = ix + iw;
  assign sxh = ix - iw;
  assign syl = iy + iw;
  assign syh = iy - iw;
  assign szl = iz + iw;
  assign nc_in = {(iz > 0), (szl < 0), (syh > 0), (syl < 0), (sxh > 0), (sxl < 0)};

  assign mask = nc_r | oc_r;
  assign pw   = pt_r[K_W];

  always_comb begin
    state_nxt   = state_r;
    new_nxt     = new_r;
    prev_nxt    = prev_r;
    pt_nxt      = pt_r;
    nc_nxt      = nc_r;
    oc_nxt      = oc_r;
    prev_oc_nxt = prev_oc_r;
    draw_nxt    = draw_r;
    pl_nxt      = pl_r;
    k_nxt       = k_r;
    ax_nxt      = ax_r;
    aold_nxt    = aold_r;
    anew_nxt    = anew_r;
    alpha_nxt   = alpha_r;
    dold_nxt    = dold_r;
    dnew_nxt    = dnew_r;
    d_nxt       = d_r;
    sum_nxt     = sum_r;
    num_nxt     = num_r;
    den_nxt     = den_r;
    prod_nxt    = prod_r;
    scl_nxt     = scl_r;
    neg_nxt     = neg_r;
    line_nxt    = line_r;
    last_nxt    = last_r;
    ex_nxt      = ex_r;
    ey_nxt      = ey_r;
    pen_x_nxt   = pen_x_r;
    pen_y_nxt   = pen_y_r;
    ov_nxt      = ov_r;
    oline_nxt   = oline_r;
    olast_nxt   = olast_r;
    osx_nxt     = osx_r;
    osy_nxt     = osy_r;
    oex_nxt     = oex_r;
    oey_nxt     = oey_r;
    ar_req      = '{start: 1'b0, op: OP_DIV};
    ar_a_init   = '0;
    ar_b_init   = '0;
    ar_operand  = '0;
    ar_steps    = '0;
    diff        = MW'(dold_r) - MW'(dnew_r);
    dold_ext    = MW'(dold_r);
    span        = ax_r ? ($signed({1'b0, win.bottom}) - $signed({1'b0, win.top}))
                       : ($signed({1'b0, win.right}) - $signed({1'b0, win.left}));
    cv          = ax_r ? ($signed((PW+1)'({1'b0, win.bottom})) - (PW+1)'(scl_r))
                       : ($signed((PW+1)'({1'b0, win.left})) + (PW+1)'(scl_r));
    upd_old     = aold_r;
    upd_new     = anew_r;
    pmul        = DW'({ar_a, ar_b[QW-1]});
    pa          = DW'(prev_r[k_r]);

    if (ov_r && out_ready) begin
      ov_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          new_nxt[0] = in_clip_x;
          new_nxt[1] = in_clip_y;
          new_nxt[2] = in_clip_z;
          new_nxt[3] = in_clip_w;
          nc_nxt     = nc_in;
          oc_nxt     = prev_oc_r;
          draw_nxt   = in_pen_down;
          state_nxt  = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        ax_nxt = 1'b0;
        if (draw_r) begin
          if ((nc_r & oc_r) != '0) begin
            state_nxt = ST_FINISH;
          end else if (mask == '0) begin
            pt_nxt    = new_r;
            line_nxt  = 1'b1;
            last_nxt  = 1'b1;
            state_nxt = ST_MSUM;
          end else begin
            aold_nxt  = '0;
            anew_nxt  = ALPHA_ONE;
            pl_nxt    = PL_XLO;
            state_nxt = ST_PDIST;
          end
        end else if (nc_r == '0) begin
          pt_nxt    = new_r;
          line_nxt  = 1'b0;
          last_nxt  = 1'b1;
          state_nxt = ST_MSUM;
        end else begin
          state_nxt = ST_FINISH;
        end
      end
      ST_PDIST: begin
        if (mask[pl_r]) begin
          dold_nxt  = pdist(prev_r[0], prev_r[1], prev_r[2], prev_r[3], pl_r);
          dnew_nxt  = pdist(new_r[0], new_r[1], new_r[2], new_r[3], pl_r);
          state_nxt = ST_PMAG;
        end else if (pl_r == PL_ZHI) begin
          state_nxt = ST_POST;
        end else begin
          pl_nxt = pl_r + 3'd1;
        end
      end
      ST_PMAG: begin
        num_nxt   = dold_ext[MW-1] ? MW'(-dold_ext) : MW'(dold_ext);
        den_nxt   = diff[MW-1] ? MW'(-diff) : MW'(diff);
        state_nxt = ST_PCHK;
      end
      ST_PCHK: begin
        if (den_r == '0) begin
          alpha_nxt = '0;
          state_nxt = ST_PUPD;
        end else if (num_r >= den_r) begin
          alpha_nxt = ALPHA_ONE;
          state_nxt = ST_PUPD;
        end else begin
          ar_req     = '{start: 1'b1, op: OP_DIV};
          ar_a_init  = RW'(num_r);
          ar_b_init  = '0;
          ar_operand = RW'(den_r);
          ar_steps   = CNTW'(FB);
          state_nxt  = ST_PDIV;
        end
      end
      ST_PDIV: begin
        if (ar_done) begin
          alpha_nxt = {1'b0, ar_b[FB-1:0]};
          state_nxt = ST_PUPD;
        end
      end
      ST_PUPD: begin
        if (oc_r[pl_r]) begin
          if (aold_r < alpha_r) begin
            upd_old = alpha_r;
          end
        end else if (anew_r > alpha_r) begin
          upd_new = alpha_r;
        end
        aold_nxt = upd_old;
        anew_nxt = upd_new;
        if (upd_old > upd_new) begin
          state_nxt = ST_FINISH;
        end else if (pl_r == PL_ZHI) begin
          state_nxt = ST_POST;
        end else begin
          pl_nxt    = pl_r + 3'd1;
          state_nxt = ST_PDIST;
        end
      end
      ST_POST: begin
        if (oc_r != '0) begin
          alpha_nxt = aold_r;
          line_nxt  = 1'b0;
          last_nxt  = 1'b0;
          k_nxt     = K_X;
          state_nxt = ST_ISUB;
        end else begin
          state_nxt = ST_EXIT;
        end
      end
      ST_EXIT: begin
        line_nxt = 1'b1;
        last_nxt = 1'b1;
        ax_nxt   = 1'b0;
        if (nc_r != '0) begin
          alpha_nxt = anew_r;
          k_nxt     = K_X;
          state_nxt = ST_ISUB;
        end else begin
          pt_nxt    = new_r;
          state_nxt = ST_MSUM;
        end
      end
      ST_ISUB: begin
        d_nxt     = DW'(new_r[k_r]) - DW'(prev_r[k_r]);
        state_nxt = ST_IMUL;
      end
      ST_IMUL: begin
        ar_req     = '{start: 1'b1, op: OP_MUL};
        ar_a_init  = '0;
        ar_b_init  = QW'(alpha_r);
        ar_operand = d_r[DW-1] ? RW'(-d_r) : RW'(d_r);
        ar_operand = d_r[DW-1] ? RW'(DW'(-d_r)) : RW'(DW'(d_r));
        ar_steps   = CNTW'(AW);
        state_nxt  = ST_IWAIT;
      end
      ST_IWAIT: begin
        if (ar_done) begin
          pt_nxt[k_r] = d_r[DW-1] ? CW'(pa - $signed(pmul)) : CW'(pa + $signed(pmul));
          if (k_r == K_W) begin
            ax_nxt    = 1'b0;
            state_nxt = ST_MSUM;
          end else begin
            k_nxt     = k_r + 2'd1;
            state_nxt = ST_ISUB;
          end
        end
      end
      ST_MSUM: begin
        if (pw[CW-1] || (pw == '0)) begin
          scl_nxt   = '0;
          state_nxt = ST_MSAT;
        end else begin
          sum_nxt   = DW'(pw) + DW'(pt_r[ax_r ? K_Y : K_X]);
          state_nxt = ST_MMUL;
        end
      end
      ST_MMUL: begin
        prod_nxt  = PW'(span) * PW'(sum_r);
        state_nxt = ST_MDIV0;
      end
      ST_MDIV0: begin
        ar_req     = '{start: 1'b1, op: OP_DIV};
        ar_a_init  = '0;
        ar_b_init  = prod_r[PW-1] ? QW'(-prod_r) : QW'(prod_r);
        ar_operand = RW'({pw, 1'b0});
        ar_steps   = CNTW'(QW);
        neg_nxt    = prod_r[PW-1];
        state_nxt  = ST_MDIV;
      end
      ST_MDIV: begin
        if (ar_done) begin
          scl_nxt   = neg_r ? -$signed(ar_b) : $signed(ar_b);
          state_nxt = ST_MSAT;
        end
      end
      ST_MSAT: begin
        if (cv < 0) begin
          if (ax_r) ey_nxt = 8'd0; else ex_nxt = 8'd0;
        end else if (cv > (PW+1)'(255)) begin
          if (ax_r) ey_nxt = 8'd255; else ex_nxt = 8'd255;
        end else begin
          if (ax_r) ey_nxt = cv[7:0]; else ex_nxt = cv[7:0];
        end
        if (ax_r) begin
          state_nxt = ST_EMIT;
        end else begin
          ax_nxt    = 1'b1;
          state_nxt = ST_MSUM;
        end
      end
      ST_EMIT: begin
        if (!ov_r || out_ready) begin
          ov_nxt    = 1'b1;
          oline_nxt = line_r;
          olast_nxt = last_r;
          osx_nxt   = pen_x_r;
          osy_nxt   = pen_y_r;
          oex_nxt   = ex_r;
          oey_nxt   = ey_r;
          pen_x_nxt = ex_r;
          pen_y_nxt = ey_r;
          state_nxt = last_r ? ST_FINISH : ST_EXIT;
        end
      end
      ST_FINISH: begin
        prev_nxt    = new_r;
        prev_oc_nxt = nc_r;
        state_nxt   = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      prev_oc_r <= '0;
      pen_x_r   <= '0;
      pen_y_r   <= '0;
      ov_r      <= 1'b0;
      for (int i = 0; i < 4; i++) begin
        prev_r[i] <= '0;
      end
    end else begin
      state_r   <= state_nxt;
      prev_oc_r <= prev_oc_nxt;
      pen_x_r   <= pen_x_nxt;
      pen_y_r   <= pen_y_nxt;
      ov_r      <= ov_nxt;
      prev_r    <= prev_nxt;
    end
    new_r   <= new_nxt;
    pt_r    <= pt_nxt;
    nc_r    <= nc_nxt;
    oc_r    <= oc_nxt;
    draw_r  <= draw_nxt;
    pl_r    <= pl_nxt;
    k_r     <= k_nxt;
    ax_r    <= ax_nxt;
    aold_r  <= aold_nxt;
    anew_r  <= anew_nxt;
    alpha_r <= alpha_nxt;
    dold_r  <= dold_nxt;
    dnew_r  <= dnew_nxt;
    d_r     <= d_nxt;
    sum_r   <= sum_nxt;
    num_r   <= num_nxt;
    den_r   <= den_nxt;
    prod_r  <= prod_nxt;
    scl_r   <= scl_nxt;
    neg_r   <= neg_nxt;
    line_r  <= line_nxt;
    last_r  <= last_nxt;
    ex_r    <= ex_nxt;
    ey_r    <= ey_nxt;
    oline_r <= oline_nxt;
    olast_r <= olast_nxt;
    osx_r   <= osx_nxt;
    osy_r   <= osy_nxt;
    oex_r   <= oex_nxt;
    oey_r   <= oey_nxt;
  end

  assign in_ready        = (state_r == ST_IDLE);
  assign out_valid       = ov_r;
  assign out_is_line     = oline_r;
  assign out_start_x     = osx_r;
  assign out_start_y     = osy_r;
  assign out_end_x       = oex_r;
  assign out_end_y       = oey_r;
  assign out_last_of_run = olast_r;

endmodule

[rtl/core/homogeneous_line_clip_viewport.sv]
// ----------------------------------------------------------------------------
// homogeneous_line_clip_viewport
// Clips move/draw commands in homogeneous clip space against six planes and
// maps the visible endpoints into an 8-bit screen window.
// ----------------------------------------------------------------------------
// Crossed planes, clipped endpoints and mapped points use the one shared
//   bit-serial divide/multiply unit.
// Throughput: one item at a time; in_ready is high only between items.
// Reset: synchronous rst_n restores window defaults, clears pen, previous
//   vertex and outcode.
// ----------------------------------------------------------------------------
module homogeneous_line_clip_viewport
  import hlc_pkg::*;
#(
  parameter int COORD_WIDTH   = DEF_COORD_WIDTH,
  parameter int FRACTION_BITS = DEF_FRACTION_BITS
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [APB_ADDR_W-1:0]         paddr,
  input  logic [APB_DATA_W-1:0]         pwdata,
  output logic [APB_DATA_W-1:0]         prdata,
  output logic                          pready,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_pen_down,
  input  logic signed [COORD_WIDTH-1:0] in_clip_x,
  input  logic signed [COORD_WIDTH-1:0] in_clip_y,
  input  logic signed [COORD_WIDTH-1:0] in_clip_z,
  input  logic signed [COORD_WIDTH-1:0] in_clip_w,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          out_is_line,
  output logic [7:0]                    out_start_x,
  output logic [7:0]                    out_start_y,
  output logic [7:0]                    out_end_x,
  output logic [7:0]                    out_end_y,
  output logic                          out_last_of_run
);

  win_t       win_r, win_nxt;
  logic       wr_en;
  logic [1:0] reg_idx;
  logic [7:0] rd_val;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[3:2];

  always_comb begin
    win_nxt = win_r;
    if (wr_en) begin
      unique case (reg_idx)
        REG_WIN_LEFT:   win_nxt.left   = pwdata[7:0];
        REG_WIN_RIGHT:  win_nxt.right  = pwdata[7:0];
        REG_WIN_TOP:    win_nxt.top    = pwdata[7:0];
        REG_WIN_BOTTOM: win_nxt.bottom = pwdata[7:0];
        default: ;
      endcase
    end
    unique case (reg_idx)
      REG_WIN_LEFT:   rd_val = win_r.left;
      REG_WIN_RIGHT:  rd_val = win_r.right;
      REG_WIN_TOP:    rd_val = win_r.top;
      REG_WIN_BOTTOM: rd_val = win_r.bottom;
      default:        rd_val = '0;
    endcase
  end

  assign prdata = APB_DATA_W'(rd_val);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r <= '{left: WIN_LEFT_RST, right: WIN_RIGHT_RST,
                 top: WIN_TOP_RST, bottom: WIN_BOTTOM_RST};
    end else begin
      win_r <= win_nxt;
    end
  end

  hlc_ctrl #(
    .COORD_WIDTH   (COORD_WIDTH),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_ctrl (
    .clk             (clk),
    .rst_n           (rst_n),
    .win             (win_r),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_pen_down     (in_pen_down),
    .in_clip_x       (in_clip_x),
    .in_clip_y       (in_clip_y),
    .in_clip_z       (in_clip_z),
    .in_clip_w       (in_clip_w),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_is_line     (out_is_line),
    .out_start_x     (out_start_x),
    .out_start_y     (out_start_y),
    .out_end_x       (out_end_x),
    .out_end_y       (out_end_y),
    .out_last_of_run (out_last_of_run)
  );

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken twice in a row");

  a_entry_is_move: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last_of_run |-> !out_is_line)
    else $error("non-final item is not a pen move");

  a_run_holds_input: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_last_of_run |=> !in_ready)
    else $error("input accepted inside a result run");

endmodule

[test/tb_top.sv]
// ----------------------------------------------------------------------------
// Line clipper testbench
// Drives move/draw vertices and window settings into the clipper, predicts
// the pen moves and line draws it must emit and compares each result field by
// field. Both channels idle at random, except in one stall-free phase.
// ----------------------------------------------------------------------------
module tb_top
  import hlc_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CW = DEF_COORD_WIDTH;
  localparam int FB = DEF_FRACTION_BITS;
  localparam longint AONE = 64'd1 << FB;
  localparam int STALL_LIMIT = 20000;

  typedef struct packed {
    logic                 pen_down;
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [CW-1:0] z;
    logic signed [CW-1:0] w;
  } vertex_cmd_t;

  typedef struct packed {
    logic       is_line;
    logic [7:0] sx;
    logic [7:0] sy;
    logic [7:0] ex;
    logic [7:0] ey;
    logic       last;
  } pen_op_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [APB_ADDR_W-1:0] paddr = '0;
  logic [APB_DATA_W-1:0] pwdata = '0;
  logic [APB_DATA_W-1:0] prdata;
  logic pready;
  logic in_valid = 1'b0;
  logic in_ready;
  logic in_pen_down = 1'b0;
  logic signed [CW-1:0] in_clip_x = '0, in_clip_y = '0, in_clip_z = '0, in_clip_w = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic out_is_line, out_last_of_run;
  logic [7:0] out_start_x, out_start_y, out_end_x, out_end_y;

  homogeneous_line_clip_viewport i_dut (.*);

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // predictor state
  longint win_l = WIN_LEFT_RST, win_r = WIN_RIGHT_RST;
  longint win_t = WIN_TOP_RST, win_b = WIN_BOTTOM_RST;
  logic [5:0] prev_code = '0;
  longint prev_v[4] = '{0, 0, 0, 0};
  logic [7:0] pen_col = '0, pen_row = '0;

  vertex_cmd_t pending_cmds[$];
  pen_op_t     expected_ops[$];
  int errors = 0;
  int n_sent = 0, n_results = 0, n_lines = 0;
  int idle_cnt = 0;
  bit stim_done = 1'b0;
  bit in_ready_seen = 1'b0;
  bit stall_free = 1'b0;
  int gap = 0;
  int out_gap = 0;

  function automatic logic [5:0] outcode(longint v[4]);
    logic [5:0] m;
    m = '0;
    m[0] = (v[0] + v[3] < 0);
    m[1] = (v[0] - v[3] > 0);
    m[2] = (v[1] + v[3] < 0);
    m[3] = (v[1] - v[3] > 0);
    m[4] = (v[2] + v[3] < 0);
    m[5] = (v[2] > 0);
    return m;
  endfunction

  function automatic longint plane_distance(longint v[4], int pl);
    case (pl)
      0: return v[0] + v[3];
      1: return v[0] - v[3];
      2: return v[1] + v[3];
      3: return v[1] - v[3];
      4: return v[2] + v[3];
      default: return v[2];
    endcase
  endfunction

  function automatic longint magnitude(longint v);
    return v < 0 ? -v : v;
  endfunction

  function automatic longint crossing_alpha(longint num, longint den);
    longint q;
    q = 0;
    if (den == 0) return 0;
    if (num >= den) return AONE;
    for (int i = 0; i < FB; i++) begin
      num = num << 1;
      q = q << 1;
      if (num >= den) begin
        num = num - den;
        q = q | 1;
      end
    end
    return q;
  endfunction

  function automatic longint lerp(longint a, longint b, longint alpha);
    longint d, m, p;
    d = b - a;
    m = magnitude(d);
    p = (m >>> FB) * alpha + (((m & (AONE - 1)) * alpha) >>> FB);
    if (p > m) p = m;
    return d < 0 ? a - p : a + p;
  endfunction

  function automatic longint span_term(longint span, longint c, longint w);
    if (w <= 0) return 0;
    return (span * (w + c)) / (2 * w);
  endfunction

  function automatic logic [7:0] clamp8(longint v);
    if (v < 0) return 8'd0;
    if (v > 255) return 8'd255;
    return v[7:0];
  endfunction

  function automatic int pick_gap();
    if (stall_free) return 0;
    if ($urandom_range(0, 15) == 0) return $urandom_range(10, 60);
    return $urandom_range(0, 2);
  endfunction

  task automatic push_pen_op(logic line, longint p[4]);
    pen_op_t o;
    o.is_line = line;
    o.sx = pen_col;
    o.sy = pen_row;
    o.ex = clamp8(win_l + span_term(win_r - win_l, p[0], p[3]));
    o.ey = clamp8(win_b - span_term(win_b - win_t, p[1], p[3]));
    o.last = 1'b0;
    pen_col = o.ex;
    pen_row = o.ey;
    expected_ops.push_back(o);
  endtask

  task automatic predict_vertex(vertex_cmd_t c);
    longint v[4], p[4];
    logic [5:0] nc, mask;
    longint a_in, a_out, dold, dnew, al;
    int n0;
    bit dropped;
    v[0] = c.x; v[1] = c.y; v[2] = c.z; v[3] = c.w;
    nc = outcode(v);
    mask = nc | prev_code;
    n0 = expected_ops.size();
    if (c.pen_down) begin
      if ((nc & prev_code) == 0) begin
        if (mask == 0) begin
          push_pen_op(1'b1, v);
        end else begin
          a_in = 0;
          a_out = AONE;
          dropped = 0;
          for (int i = 0; i < 6; i++) begin
            if (mask[i] && !dropped) begin
              dold = plane_distance(prev_v, i);
              dnew = plane_distance(v, i);
              al = crossing_alpha(magnitude(dold), magnitude(dold - dnew));
              if (prev_code[i]) begin
                if (a_in < al) a_in = al;
              end else if (a_out > al) begin
                a_out = al;
              end
              if (a_in > a_out) dropped = 1;
            end
          end
          if (!dropped) begin
            if (prev_code != 0) begin
              for (int k = 0; k < 4; k++) p[k] = lerp(prev_v[k], v[k], a_in);
              push_pen_op(1'b0, p);
            end
            if (nc != 0) begin
              for (int k = 0; k < 4; k++) p[k] = lerp(prev_v[k], v[k], a_out);
              push_pen_op(1'b1, p);
            end else begin
              push_pen_op(1'b1, v);
            end
          end
        end
      end
    end else if (nc == 0) begin
      push_pen_op(1'b0, v);
    end
    if (expected_ops.size() > n0) expected_ops[expected_ops.size() - 1].last = 1'b1;
    prev_code = nc;
    for (int k = 0; k < 4; k++) prev_v[k] = v[k];
  endtask

  // driver: feeds pending vertices with random gaps
  always @(negedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) begin
        // accepted at the coming rising edge; handled in the monitor
      end
      if (!in_valid || in_ready_seen) begin
        if (gap > 0) begin
          gap <= gap - 1;
          in_valid <= 1'b0;
        end else if (pending_cmds.size() > 0) begin
          in_valid <= 1'b1;
          {in_pen_down, in_clip_x, in_clip_y, in_clip_z, in_clip_w} <= pending_cmds.pop_front();
          gap <= pick_gap();
        end else begin
          in_valid <= 1'b0;
        end
      end
      if (out_gap > 0) begin
        out_gap <= out_gap - 1;
        out_ready <= 1'b0;
      end else if (!stall_free && $urandom_range(0, 3) == 0) begin
        out_gap <= pick_gap();
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // monitor: predicts on acceptance, checks results
  always @(posedge clk) begin
    in_ready_seen <= rst_n && in_valid && in_ready;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        predict_vertex({in_pen_down, in_clip_x, in_clip_y, in_clip_z, in_clip_w});
        n_sent++;
      end
      if (out_valid && out_ready) begin
        n_results++;
        if (out_is_line) n_lines++;
        if (expected_ops.size() == 0) begin
          $display("%0t: unexpected result line=%0b (%0d,%0d)->(%0d,%0d)", $realtime,
                   out_is_line, out_start_x, out_start_y, out_end_x, out_end_y);
          errors++;
        end else begin
          pen_op_t e;
          e = expected_ops.pop_front();
          if ({out_is_line, out_start_x, out_start_y, out_end_x, out_end_y, out_last_of_run}
              !== e) begin
            $display("%0t: mismatch expected line=%0b (%0d,%0d)->(%0d,%0d) last=%0b",
                     $realtime, e.is_line, e.sx, e.sy, e.ex, e.ey, e.last);
            $display("%0t:          actual   line=%0b (%0d,%0d)->(%0d,%0d) last=%0b",
                     $realtime, out_is_line, out_start_x, out_start_y, out_end_x, out_end_y,
                     out_last_of_run);
            errors++;
          end
        end
      end
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        idle_cnt <= 0;
      end else begin
        idle_cnt <= idle_cnt + 1;
        if (idle_cnt >= STALL_LIMIT) begin
          $display("%0t: timeout, %0d results outstanding", $realtime, expected_ops.size());
          $display("FAIL homogeneous_line_clip_viewport");
          $finish;
        end
      end
    end
  end

  task automatic write_window(logic [1:0] idx, logic [7:0] val);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= APB_ADDR_W'(idx) << 2;
    pwdata <= APB_DATA_W'(val);
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_WIN_LEFT:   win_l = val;
      REG_WIN_RIGHT:  win_r = val;
      REG_WIN_TOP:    win_t = val;
      default:        win_b = val;
    endcase
  endtask

  task automatic drain();
    while (pending_cmds.size() > 0 || in_valid || expected_ops.size() > 0) @(negedge clk);
    repeat (1500) @(negedge clk);
  endtask

  function automatic logic signed [CW-1:0] rand_coord(int mode);
    case (mode)
      0: return $urandom();
      1: return $signed($urandom_range(0, 32'h0004_0000)) - 32'sh0002_0000;
      default: return $signed($urandom_range(0, 32'h0000_1000)) - 32'sh0000_0800;
    endcase
  endfunction

  task automatic queue_vertex(logic pd, logic signed [CW-1:0] x, logic signed [CW-1:0] y,
                              logic signed [CW-1:0] z, logic signed [CW-1:0] w);
    vertex_cmd_t c;
    c = '{pd, x, y, z, w};
    pending_cmds.push_back(c);
  endtask

  task automatic queue_random(int count);
    int mode;
    logic signed [CW-1:0] w;
    for (int i = 0; i < count; i++) begin
      mode = $urandom_range(0, 9);
      if (mode == 0) begin
        queue_vertex(1'($urandom_range(0, 1)), $urandom(), $urandom(), $urandom(), $urandom());
      end else begin
        w = (mode < 7) ? $signed($urandom_range(32'h0000_4000, 32'h0002_0000))
                       : rand_coord(2);
        queue_vertex($urandom_range(0, 5) != 0, rand_coord(mode < 5 ? 1 : 2),
                     rand_coord(mode < 5 ? 1 : 2), -$signed($urandom_range(0, 32'h0003_0000))
                     + ($urandom_range(0, 7) == 0 ? 32'sh0001_0000 : 0), w);
      end
    end
  endtask

  localparam logic signed [CW-1:0] ONE = 32'sh0001_0000;
  localparam logic signed [CW-1:0] MAXC = 32'sh7fff_ffff;
  localparam logic signed [CW-1:0] MINC = 32'sh8000_0000;

  initial begin
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    // directed: inside, trivial reject, entry/exit clip, degenerate w, extremes
    queue_vertex(1'b0, 0, 0, -ONE / 2, ONE);
    queue_vertex(1'b1, ONE / 2, -ONE / 2, -ONE / 2, ONE);
    queue_vertex(1'b1, 3 * ONE, 0, -ONE / 2, ONE);
    queue_vertex(1'b1, 4 * ONE, 0, -ONE / 2, ONE);
    queue_vertex(1'b1, 0, -3 * ONE, -ONE / 2, ONE);
    queue_vertex(1'b1, 0, 3 * ONE, -ONE / 2, ONE);
    queue_vertex(1'b1, 0, 0, -3 * ONE, ONE);
    queue_vertex(1'b1, 0, 0, ONE, ONE);
    queue_vertex(1'b0, 2 * ONE, 2 * ONE, -ONE / 2, ONE);
    queue_vertex(1'b1, -3 * ONE, -ONE / 4, -ONE / 2, ONE);
    queue_vertex(1'b1, -ONE, ONE, -ONE, ONE);
    queue_vertex(1'b0, 0, 0, 0, 0);
    queue_vertex(1'b1, 0, 0, 0, -ONE);
    queue_vertex(1'b1, MAXC, MINC, MAXC, MINC);
    queue_vertex(1'b0, MINC, MAXC, MINC, MAXC);
    queue_vertex(1'b1, MAXC, MAXC, MINC, MAXC);
    queue_vertex(1'b0, -1, -1, -1, 32'sh0000_0001);
    queue_vertex(1'b1, ONE, ONE, -ONE, ONE);
    queue_vertex(1'b1, 0, 0, -ONE, 0);
    drain();
    write_window(REG_WIN_LEFT, 8'd255);
    write_window(REG_WIN_RIGHT, 8'd0);
    write_window(REG_WIN_TOP, 8'd255);
    write_window(REG_WIN_BOTTOM, 8'd0);
    queue_random(150);
    drain();
    write_window(REG_WIN_LEFT, 8'd0);
    write_window(REG_WIN_RIGHT, 8'd255);
    write_window(REG_WIN_TOP, 8'd0);
    write_window(REG_WIN_BOTTOM, 8'd255);
    stall_free = 1'b1;
    queue_random(150);
    drain();
    stall_free = 1'b0;
    for (int ph = 0; ph < 4; ph++) begin
      write_window(REG_WIN_LEFT, 8'($urandom()));
      write_window(REG_WIN_RIGHT, 8'($urandom()));
      write_window(REG_WIN_TOP, 8'($urandom()));
      write_window(REG_WIN_BOTTOM, 8'($urandom()));
      queue_random(135);
      drain();
    end
    $display("Sent %0d vertices over seven window settings; checked %0d results (%0d lines).",
             n_sent, n_results, n_lines);
    if (errors == 0) begin
      $display("PASS homogeneous_line_clip_viewport");
    end else begin
      $display("FAIL homogeneous_line_clip_viewport");
    end
    $finish;
  end
endmodule

[filelist.f]
rtl/core/hlc_pkg.sv
rtl/core/hlc_arith.sv
rtl/core/hlc_ctrl.sv
rtl/core/homogeneous_line_clip_viewport.sv
test/tb_top.sv
